// ----- rtl/core/paerq_pkg.sv -----
package paerq_pkg;

    localparam int MAX_LEVELS_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;

    // Effective level count is at most 7, since levels_in_use is three bits, so five bits cover it
    localparam int EFF_W = 5;

    localparam logic [2:0] LEVELS_RESET = 3'd4;

    localparam logic        REQ_ADD  = 1'b0;
    localparam logic        REQ_TAKE = 1'b1;

    localparam logic [2:0]  DYN_EXHAUSTED = 3'b111;

    localparam logic [1:0]  STATUS_DONE  = 2'd0;
    localparam logic [1:0]  STATUS_EMPTY = 2'd1;
    localparam logic [1:0]  STATUS_FULL  = 2'd2;
    localparam logic [1:0]  STATUS_RANGE = 2'd3;

    typedef struct packed {
        logic issue_add;
        logic issue_take;
        logic load_grant;
    } paerq_cmd_t;

endpackage

// ----- rtl/core/paerq_ram.sv -----
module paerq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/paerq_ctrl.sv -----
module paerq_ctrl
    import paerq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    output logic       out_valid,
    input  logic       out_ready,
    output paerq_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // Take a request only when the result slot is free or draining now
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.issue_add  = accept && (req_type == REQ_ADD);
        cmd.issue_take = accept && (req_type == REQ_TAKE);
        cmd.load_grant = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.issue_add)
                begin
                    out_valid_next = 1'b1;
                end
                if (cmd.issue_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/paerq_dp.sv -----
module paerq_dp
    import paerq_pkg::*;
#(
    parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  paerq_cmd_t              cmd,
    input  logic [TASK_ID_BITS-1:0] task_id,
    input  logic signed [2:0]       dynamic_level,
    input  logic [2:0]              static_level,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              levels_in_use,
    output logic [1:0]              status,
    output logic [TASK_ID_BITS-1:0] out_task_id,
    output logic [1:0]              out_level,
    output logic                    went_expired,
    output logic                    banks_swapped
);

    localparam int NF    = 2 * MAX_LEVELS;
    localparam int QW    = $clog2(NF);
    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = $clog2(2 * QUEUE_DEPTH);
    localparam int DEPTH = NF * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [HW-1:0]           head_reg [NF];
    logic [CW-1:0]           count_reg [NF];
    logic                    active_reg;
    logic [2:0]              levels_reg;

    logic [1:0]              status_reg;
    logic [TASK_ID_BITS-1:0] id_reg;
    logic [1:0]              level_reg;
    logic                    expired_reg;
    logic                    swapped_reg;
    logic                    got_reg;

    logic [EFF_W-1:0]        eff;
    logic [QW-1:0]           base_act;
    logic [QW-1:0]           base_oth;
    logic                    found_a;
    logic                    found_b;
    logic [LVL_W-1:0]        lvl_a;
    logic [LVL_W-1:0]        lvl_b;

    logic                    add_exh;
    logic [3:0]              add_lvl_s;
    logic                    add_bank;
    logic                    add_in_range;
    logic [LVL_W-1:0]        add_lvl;
    logic [QW-1:0]           add_q;
    logic                    add_full;
    logic [SW-1:0]           tail_sum;
    logic [SW-1:0]           tail_slot;
    logic                    add_we;
    logic [AW-1:0]           waddr;

    logic                    take_swap;
    logic                    take_got;
    logic                    take_bank;
    logic [LVL_W-1:0]        take_lvl;
    logic [QW-1:0]           take_q;
    logic [HW-1:0]           head_adv;
    logic [AW-1:0]           raddr;
    logic [TASK_ID_BITS-1:0] rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (EFF_W'(levels_reg) > EFF_W'(MAX_LEVELS))
        begin
            eff = EFF_W'(MAX_LEVELS);
        end
        else
        begin
            eff = EFF_W'(levels_reg);
        end
    end

    // Highest non-empty level in use, for each bank
    always_comb
    begin
        base_act = active_reg ? QW'(MAX_LEVELS) : '0;
        base_oth = active_reg ? '0 : QW'(MAX_LEVELS);
        found_a  = 1'b0;
        found_b  = 1'b0;
        lvl_a    = '0;
        lvl_b    = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (EFF_W'(i) < eff)
            begin
                if (count_reg[base_act + QW'(i)] != '0)
                begin
                    found_a = 1'b1;
                    lvl_a   = LVL_W'(i);
                end
                if (count_reg[base_oth + QW'(i)] != '0)
                begin
                    found_b = 1'b1;
                    lvl_b   = LVL_W'(i);
                end
            end
        end
    end

    // Add: pick bank and level, append at the tail
    always_comb
    begin
        add_exh      = (dynamic_level == DYN_EXHAUSTED);
        add_lvl_s    = add_exh ? ({1'b0, static_level} - 4'd1)
                               : {dynamic_level[2], dynamic_level};
        add_bank     = add_exh ? ~active_reg : active_reg;
        add_in_range = !add_lvl_s[3] && (EFF_W'(add_lvl_s[2:0]) < eff);
        add_lvl      = LVL_W'(add_lvl_s[2:0]);
        add_q        = (add_bank ? QW'(MAX_LEVELS) : QW'(0)) + QW'(add_lvl);
        add_full     = (count_reg[add_q] == CW'(QUEUE_DEPTH));
        tail_sum     = SW'(head_reg[add_q]) + SW'(count_reg[add_q]);
        if (tail_sum >= SW'(QUEUE_DEPTH))
        begin
            tail_slot = tail_sum - SW'(QUEUE_DEPTH);
        end
        else
        begin
            tail_slot = tail_sum;
        end
        add_we = cmd.issue_add && add_in_range && !add_full;
        waddr  = AW'(add_q) * AW'(QUEUE_DEPTH) + AW'(tail_slot);
    end

    // Take: active bank first, else swap and use the other bank
    always_comb
    begin
        take_swap = !found_a;
        take_got  = found_a || found_b;
        take_bank = found_a ? active_reg : ~active_reg;
        take_lvl  = found_a ? lvl_a : lvl_b;
        take_q    = (take_bank ? QW'(MAX_LEVELS) : QW'(0)) + QW'(take_lvl);
        if (head_reg[take_q] == HW'(QUEUE_DEPTH - 1))
        begin
            head_adv = '0;
        end
        else
        begin
            head_adv = head_reg[take_q] + HW'(1);
        end
        raddr = AW'(take_q) * AW'(QUEUE_DEPTH) + AW'(head_reg[take_q]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NF; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            active_reg <= 1'b0;
            levels_reg <= LEVELS_RESET;
        end
        else
        begin
            if (add_we)
            begin
                count_reg[add_q] <= count_reg[add_q] + CW'(1);
            end
            if (cmd.issue_take && take_got)
            begin
                head_reg[take_q]  <= head_adv;
                count_reg[take_q] <= count_reg[take_q] - CW'(1);
            end
            if (cmd.issue_take && take_swap)
            begin
                active_reg <= ~active_reg;
            end
            if (cfg_valid)
            begin
                levels_reg <= levels_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue_add)
        begin
            if (!add_in_range)
            begin
                status_reg <= STATUS_RANGE;
            end
            else if (add_full)
            begin
                status_reg <= STATUS_FULL;
            end
            else
            begin
                status_reg <= STATUS_DONE;
            end
            id_reg      <= task_id;
            level_reg   <= add_in_range ? 2'(add_lvl) : 2'd0;
            expired_reg <= add_in_range && !add_full && add_exh;
            swapped_reg <= 1'b0;
        end
        if (cmd.issue_take)
        begin
            status_reg  <= take_got ? STATUS_DONE : STATUS_EMPTY;
            level_reg   <= take_got ? 2'(take_lvl) : 2'd0;
            expired_reg <= 1'b0;
            swapped_reg <= take_swap;
            got_reg     <= take_got;
        end
        if (cmd.load_grant)
        begin
            id_reg <= got_reg ? rdata : '0;
        end
    end

    paerq_ram #(
        .WIDTH (TASK_ID_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (add_we),
        .waddr (waddr),
        .wdata (task_id),
        .re    (cmd.issue_take),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status        = status_reg;
    assign out_task_id   = id_reg;
    assign out_level     = level_reg;
    assign went_expired  = expired_reg;
    assign banks_swapped = swapped_reg;

endmodule

// ----- rtl/core/priority_active_expired_ready_queue_core.sv -----
// Two-bank (active / expired) multilevel ready queue.
// Request channel in_valid/in_ready carries req_type, task_id, dynamic_level
// and static_level. An add appends the task to one FIFO; a take pops the
// head of the highest non-empty level of the active bank, swapping banks
// when the active bank has nothing in the levels in use.
// Result channel out_valid/out_ready returns exactly one result per request:
// status, out_task_id, out_level, went_expired, banks_swapped.
// Config channel cfg_valid/cfg_ready writes levels_in_use; write it only
// while no request is outstanding.
// An add result is registered and valid in the cycle after acceptance; a take
// result goes through the READ state first, since the task id comes out of the
// registered read of the task store RAM. Adds can be taken every cycle while
// out_ready is high; none is taken in READ. One request is in flight at a time.
// A result waits in the output register while out_ready is low; the next
// request is taken in the same cycle the waiting result is taken.
// Reset empties every FIFO, makes bank zero active and sets levels_in_use
// to 4. The task store itself is not cleared and no clearing pass runs.
module priority_active_expired_ready_queue_core
    import paerq_pkg::*;
#(
    parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [TASK_ID_BITS-1:0] task_id,
    input  logic signed [2:0]       dynamic_level,
    input  logic [2:0]              static_level,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [TASK_ID_BITS-1:0] out_task_id,
    output logic [1:0]              out_level,
    output logic                    went_expired,
    output logic                    banks_swapped,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              levels_in_use
);

    paerq_cmd_t cmd;

    paerq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    paerq_dp #(
        .MAX_LEVELS   (MAX_LEVELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .task_id       (task_id),
        .dynamic_level (dynamic_level),
        .static_level  (static_level),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .levels_in_use (levels_in_use),
        .status        (status),
        .out_task_id   (out_task_id),
        .out_level     (out_level),
        .went_expired  (went_expired),
        .banks_swapped (banks_swapped)
    );

endmodule

// ----- sim/paerq_dispatch_checker.sv -----
module paerq_dispatch_checker
    import paerq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        req_type,
    input  logic [TASK_ID_BITS_DEF-1:0] task_id,
    input  logic signed [2:0]           dynamic_level,
    input  logic [2:0]                  static_level,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [1:0]                  status,
    input  logic [TASK_ID_BITS_DEF-1:0] out_task_id,
    input  logic [1:0]                  out_level,
    input  logic                        went_expired,
    input  logic                        banks_swapped,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [2:0]                  levels_in_use,
    output int                          mismatch_count,
    output int                          pending_results,
    output int                          results_checked,
    output int                          adds_refused,
    output int                          swaps_seen
);

    localparam int LV        = MAX_LEVELS_DEF;
    localparam int DEPTH     = QUEUE_DEPTH_DEF;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH_DEF);
    localparam int EXP_SLOTS = 16;

    typedef struct packed {
        logic [1:0]                  status;
        logic [TASK_ID_BITS_DEF-1:0] task_id;
        logic [1:0]                  level;
        logic                        expired;
        logic                        swapped;
    } dispatch_result_t;

    logic [TASK_ID_BITS_DEF-1:0] id_ring [2*LV][DEPTH];
    logic [PTR_W-1:0]            ring_head [2*LV];
    logic [PTR_W:0]              ring_fill [2*LV];
    logic                        cur_bank;
    logic [2:0]                  levels_reg;

    dispatch_result_t exp_ring [EXP_SLOTS];
    int               exp_rd;
    int               exp_wr;
    int               exp_count;
    dispatch_result_t want;
    dispatch_result_t got;
    int               errors;
    int               checked;
    int               refused;
    int               swaps;

    function automatic int levels_searched();
        return (int'(levels_reg) > LV) ? LV : int'(levels_reg);
    endfunction

    task automatic pop_top(input logic bank, output logic found,
                           output logic [TASK_ID_BITS_DEF-1:0] id, output logic [1:0] lvl);
        int q;
        found = 1'b0;
        id    = '0;
        lvl   = '0;
        for (int i = levels_searched() - 1; i >= 0; i--) begin
            q = int'(bank) * LV + i;
            if (!found && ring_fill[q] != 0) begin
                id           = id_ring[q][ring_head[q]];
                lvl          = i[1:0];
                ring_head[q] = ring_head[q] + 1'b1;
                ring_fill[q] = ring_fill[q] - 1'b1;
                found        = 1'b1;
            end
        end
    endtask

    task automatic predict_dispatch(input logic rt, input logic [TASK_ID_BITS_DEF-1:0] id,
                                    input logic signed [2:0] dl, input logic [2:0] sl,
                                    output dispatch_result_t r);
        int                          lvl;
        int                          q;
        int                          tail;
        logic                        bank;
        logic                        found;
        logic [TASK_ID_BITS_DEF-1:0] gid;
        logic [1:0]                  glvl;
        r        = '0;
        r.status = STATUS_DONE;
        if (rt == REQ_ADD) begin
            r.task_id = id;
            // exhausted task drops to static-1 in the other bank
            if (dl == DYN_EXHAUSTED) begin
                lvl  = int'(sl) - 1;
                bank = ~cur_bank;
            end
            else begin
                lvl  = int'(dl);
                bank = cur_bank;
            end
            if (lvl < 0 || lvl >= levels_searched()) begin
                r.status = STATUS_RANGE;
            end
            else begin
                q       = int'(bank) * LV + lvl;
                r.level = lvl[1:0];
                if (ring_fill[q] >= DEPTH) begin
                    r.status = STATUS_FULL;
                end
                else begin
                    tail              = (int'(ring_head[q]) + int'(ring_fill[q])) % DEPTH;
                    id_ring[q][tail]  = id;
                    ring_fill[q]      = ring_fill[q] + 1'b1;
                    r.expired         = (dl == DYN_EXHAUSTED);
                end
            end
        end
        else begin
            pop_top(cur_bank, found, gid, glvl);
            if (!found) begin
                cur_bank  = ~cur_bank;
                r.swapped = 1'b1;
                pop_top(cur_bank, found, gid, glvl);
            end
            if (found) begin
                r.task_id = gid;
                r.level   = glvl;
            end
            else begin
                r.status = STATUS_EMPTY;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int q = 0; q < 2*LV; q++) begin
                ring_head[q] = '0;
                ring_fill[q] = '0;
            end
            cur_bank   = 1'b0;
            levels_reg = LEVELS_RESET;
            exp_rd     = 0;
            exp_wr     = 0;
            exp_count  = 0;
            errors  = 0;
            checked = 0;
            refused = 0;
            swaps   = 0;
        end
        else begin
            // retire the result before taking the next request in the same cycle
            if (out_valid && out_ready) begin
                got = '{status, out_task_id, out_level, went_expired, banks_swapped};
                if (exp_count == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status %0d id %02h level %0d exp %0b swap %0b",
                                 got.status, got.task_id, got.level, got.expired, got.swapped);
                end
                else begin
                    want      = exp_ring[exp_rd];
                    exp_rd    = (exp_rd + 1) % EXP_SLOTS;
                    exp_count = exp_count - 1;
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result %0d mismatch (expected/actual): status %0d/%0d ",
                                      "id %02h/%02h level %0d/%0d exp %0b/%0b swap %0b/%0b"},
                                     checked, want.status, got.status, want.task_id,
                                     got.task_id, want.level, got.level, want.expired,
                                     got.expired, want.swapped, got.swapped);
                    end
                    checked++;
                end
            end
            if (in_valid && in_ready) begin
                predict_dispatch(req_type, task_id, dynamic_level, static_level, want);
                if (want.status == STATUS_FULL || want.status == STATUS_RANGE)
                    refused++;
                if (want.swapped)
                    swaps++;
                exp_ring[exp_wr] = want;
                exp_wr           = (exp_wr + 1) % EXP_SLOTS;
                exp_count        = exp_count + 1;
            end
            if (cfg_valid && cfg_ready)
                levels_reg = levels_in_use;
        end
        mismatch_count  <= errors;
        pending_results <= exp_count;
        results_checked <= checked;
        adds_refused    <= refused;
        swaps_seen      <= swaps;
    end

endmodule

// ----- sim/priority_active_expired_ready_queue_core_tb.sv -----
module priority_active_expired_ready_queue_core_tb;
    import paerq_pkg::*;

    localparam int STALL_LIMIT = 500;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        in_valid      = 1'b0;
    logic                        in_ready;
    logic                        req_type      = REQ_ADD;
    logic [TASK_ID_BITS_DEF-1:0] task_id       = '0;
    logic signed [2:0]           dynamic_level = '0;
    logic [2:0]                  static_level  = '0;
    logic                        out_valid;
    logic                        out_ready     = 1'b0;
    logic [1:0]                  status;
    logic [TASK_ID_BITS_DEF-1:0] out_task_id;
    logic [1:0]                  out_level;
    logic                        went_expired;
    logic                        banks_swapped;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [2:0]                  levels_in_use = LEVELS_RESET;

    logic calm      = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   requests_sent = 0;
    int   settings_done = 0;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int adds_refused;
    int swaps_seen;

    always #5 clk = ~clk;

    priority_active_expired_ready_queue_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .task_id       (task_id),
        .dynamic_level (dynamic_level),
        .static_level  (static_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_task_id   (out_task_id),
        .out_level     (out_level),
        .went_expired  (went_expired),
        .banks_swapped (banks_swapped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .levels_in_use (levels_in_use)
    );

    paerq_dispatch_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .task_id         (task_id),
        .dynamic_level   (dynamic_level),
        .static_level    (static_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .out_task_id     (out_task_id),
        .out_level       (out_level),
        .went_expired    (went_expired),
        .banks_swapped   (banks_swapped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .levels_in_use   (levels_in_use),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .adds_refused    (adds_refused),
        .swaps_seen      (swaps_seen)
    );

    // result side: random stalls between ready runs, always ready once calm is set
    always @(posedge clk) begin
        if (calm) begin
            out_ready <= 1'b1;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        else if (out_ready) begin
            if ($urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                hold_left <= $urandom_range(0, 10);
            end
        end
        else begin
            out_ready <= 1'b1;
            hold_left <= $urandom_range(0, 15);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("priority_active_expired_ready_queue_core test failed");
            $finish;
        end
    end

    // valid stays high across back-to-back requests; drop it only for a gap
    task automatic send_request(input logic rt, input logic [TASK_ID_BITS_DEF-1:0] id,
                                input logic [2:0] dl, input logic [2:0] sl);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= rt;
        task_id       <= id;
        dynamic_level <= dl;
        static_level  <= sl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic write_levels(input logic [2:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid     <= 1'b1;
        levels_in_use <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // push past the FIFO depth on one level so the full case shows up
    task automatic fill_one_level(input int eff);
        logic [2:0] dl;
        logic [2:0] sl;
        int         lv;
        lv = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
        if ($urandom_range(0, 1)) begin
            dl = DYN_EXHAUSTED;
            sl = 3'(lv + 1);
        end
        else begin
            dl = 3'(lv);
            sl = 3'($urandom_range(1, 4));
        end
        repeat (QUEUE_DEPTH_DEF + 2)
            send_request(REQ_ADD, TASK_ID_BITS_DEF'($urandom), dl, sl);
    endtask

    task automatic run_random(input int n_items, input int eff);
        int         mode;
        int         flood_at;
        logic [2:0] dl;
        logic [2:0] sl;
        flood_at = $urandom_range(0, n_items - 1);
        for (int k = 0; k < n_items; k++) begin
            if (k == flood_at)
                fill_one_level(eff);
            mode = $urandom_range(0, 99);
            if (mode < 40) begin
                send_request(REQ_TAKE, TASK_ID_BITS_DEF'($urandom), 3'($urandom),
                             3'($urandom));
            end
            else if (mode < 88) begin
                if (eff == 0 || $urandom_range(0, 3) == 0) begin
                    dl = DYN_EXHAUSTED;
                    sl = (eff == 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(1, eff));
                end
                else begin
                    dl = 3'($urandom_range(0, eff - 1));
                    sl = 3'($urandom_range(1, 4));
                end
                send_request(REQ_ADD, TASK_ID_BITS_DEF'($urandom), dl, sl);
            end
            else begin
                send_request(1'($urandom), TASK_ID_BITS_DEF'($urandom), 3'($urandom),
                             3'($urandom));
            end
        end
    endtask

    initial begin
        logic [2:0] settings [8];
        int         eff;
        settings = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all four levels after reset
        send_request(REQ_TAKE, 8'h00, 3'd0, 3'd0);
        send_request(REQ_ADD, 8'h00, 3'd0, 3'd1);
        send_request(REQ_ADD, 8'hFF, 3'd3, 3'd7);
        send_request(REQ_ADD, 8'hA5, DYN_EXHAUSTED, 3'd1);
        send_request(REQ_ADD, 8'h5A, DYN_EXHAUSTED, 3'd4);
        send_request(REQ_ADD, 8'h11, DYN_EXHAUSTED, 3'd0);
        send_request(REQ_ADD, 8'h22, DYN_EXHAUSTED, 3'd5);
        send_request(REQ_ADD, 8'h33, DYN_EXHAUSTED, 3'd7);
        send_request(REQ_ADD, 8'h44, 3'b110, 3'd2);
        send_request(REQ_ADD, 8'h55, 3'b100, 3'd3);
        send_request(REQ_ADD, 8'h80, 3'd2, 3'd3);
        send_request(REQ_ADD, 8'h7F, 3'd2, 3'd2);
        repeat (4) send_request(REQ_TAKE, 8'hFF, 3'b111, 3'b111);
        repeat (4) send_request(REQ_TAKE, 8'h00, 3'd0, 3'd0);

        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                calm <= 1'b1;
            write_levels(settings[p]);
            eff = (settings[p] > 3'd4) ? 4 : int'(settings[p]);
            run_random((settings[p] == 3'd0) ? 25 : 60, eff);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests over %0d level settings, %0d results checked",
                 requests_sent, settings_done + 1, results_checked);
        $display("%0d adds refused as full or out of range, %0d bank swaps",
                 adds_refused, swaps_seen);
        if (mismatch_count == 0)
            $display("priority_active_expired_ready_queue_core test passed");
        else
            $display("priority_active_expired_ready_queue_core test failed");
        $finish;
    end

endmodule

// ----- priority_active_expired_ready_queue_core.f -----
rtl/core/paerq_pkg.sv
rtl/core/paerq_ram.sv
rtl/core/paerq_ctrl.sv
rtl/core/paerq_dp.sv
rtl/core/priority_active_expired_ready_queue_core.sv
sim/paerq_dispatch_checker.sv
sim/priority_active_expired_ready_queue_core_tb.sv
